### rtl/rgg_pkg.sv
// ----------------------------------------------------------------------------
// rgg_pkg
// Shared types, constants and elaboration-time tables for the radial
// gradient pixel generator.
// ----------------------------------------------------------------------------
package rgg_pkg;

	localparam int COORD_BITS  = 12;
	localparam int COLOUR_BITS = 16;
	localparam int PIX_W       = 12;
	localparam int CH_W        = 16;
	localparam int CFG_W       = 64;
	localparam int IDX_W       = 3;

	localparam int SQRT_STAGES = 16;  // two root bits per stage
	localparam int DIV_STEPS   = 17;  // one quotient bit per stage
	localparam int POW_STEPS   = 16;

	localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [CH_W-1:0]  CH_MAX     = CH_W'((64'd1 << COLOUR_BITS) - 64'd1);
	localparam logic [16:0]      T_ONE      = 17'h10000;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW_X,
		REG_ROW_Y,
		REG_CENTRE,
		REG_RADII,
		REG_GAMMA,
		REG_START_COLOUR,
		REG_END_COLOUR
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_INNER,
		CLS_OUTER,
		CLS_MID
	} cls_t;

	typedef struct packed {
		logic [63:0] row_x;
		logic [63:0] row_y;
		logic [63:0] centre;
		logic [63:0] r1sq;
		logic [63:0] r2sq;
		logic        r_le;
	} geom_cfg_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef logic [30:0] root_tab_t [POW_STEPS];

	// one step of the digit-by-digit square root
	function automatic sq_t sqrt_step(input sq_t a, input logic [1:0] bb);
		logic [35:0] cur;
		logic [35:0] trial;
		sq_t r;
		cur   = {a.rem, bb};
		trial = {2'b00, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = 34'(cur - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = cur[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [31:0] isqrt64(input logic [63:0] v);
		sq_t s;
		s = '0;
		for (int i = 31; i >= 0; i--) begin
			s = sqrt_step(s, v[2*i+1 -: 2]);
		end
		return s.root;
	endfunction

	// Q30 roots 2^(2^-k), k = 1..16
	function automatic root_tab_t calc_roots();
		root_tab_t tab;
		logic [31:0] r;
		r = isqrt64(64'd1 << 61);
		for (int k = 0; k < POW_STEPS; k++) begin
			tab[k] = r[30:0];
			r = isqrt64({2'b00, r, 30'b0});
		end
		return tab;
	endfunction

	localparam root_tab_t EXP_ROOTS = calc_roots();

endpackage

### rtl/rgg_geom.sv
// ----------------------------------------------------------------------------
// rgg_geom
// Affine transform, squared distance to the centre and radius classing.
// ----------------------------------------------------------------------------
module rgg_geom (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [rgg_pkg::PIX_W-1:0] pixel_x,
	input  logic [rgg_pkg::PIX_W-1:0] pixel_y,
	input  rgg_pkg::geom_cfg_t       cfg,
	output logic                     out_vld,
	output logic [63:0]              dsq,
	output rgg_pkg::cls_t            out_cls
);

	logic signed [19:0] xa, xb, ya, yb;
	logic signed [23:0] xo, yo;
	logic signed [12:0] xs, ys;

	logic signed [32:0] mxa_s1, mxb_s1, mya_s1, myb_s1;
	logic [34:0]        qx_s2, qy_s2;
	logic [31:0]        ax_s3, ay_s3;
	logic               far_s3;
	logic [63:0]        sx_s4, sy_s4;
	logic               far_s4;
	logic [63:0]        dist_s5;
	logic               far_s5;
	logic [63:0]        dist_s6;
	rgg_pkg::cls_t      cls_s6;
	logic [6:1]         vld_s;

	logic [35:0] dx, dy, adx, ady;
	logic [64:0] dsum;

	assign xa = cfg.row_x[19:0];
	assign xb = cfg.row_x[39:20];
	assign xo = cfg.row_x[63:40];
	assign ya = cfg.row_y[19:0];
	assign yb = cfg.row_y[39:20];
	assign yo = cfg.row_y[63:40];
	assign xs = {1'b0, pixel_x & rgg_pkg::COORD_MASK};
	assign ys = {1'b0, pixel_y & rgg_pkg::COORD_MASK};

	// centre minus mapped point, magnitude
	assign dx  = {{4{cfg.centre[31]}}, cfg.centre[31:0]} - {qx_s2[34], qx_s2};
	assign dy  = {{4{cfg.centre[63]}}, cfg.centre[63:32]} - {qy_s2[34], qy_s2};
	assign adx = dx[35] ? 36'(-dx) : dx;
	assign ady = dy[35] ? 36'(-dy) : dy;
	assign dsum = {1'b0, sx_s4} + {1'b0, sy_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxa_s1 <= xs * xa;
			mxb_s1 <= ys * xb;
			mya_s1 <= xs * ya;
			myb_s1 <= ys * yb;

			qx_s2 <= {{2{mxa_s1[32]}}, mxa_s1} + {{2{mxb_s1[32]}}, mxb_s1}
				+ {{3{xo[23]}}, xo, 8'b0};
			qy_s2 <= {{2{mya_s1[32]}}, mya_s1} + {{2{myb_s1[32]}}, myb_s1}
				+ {{3{yo[23]}}, yo, 8'b0};

			ax_s3  <= adx[31:0];
			ay_s3  <= ady[31:0];
			far_s3 <= (|adx[35:32]) | (|ady[35:32]);

			sx_s4  <= ax_s3 * ax_s3;
			sy_s4  <= ay_s3 * ay_s3;
			far_s4 <= far_s3;

			dist_s5 <= dsum[63:0];
			far_s5  <= far_s4 | dsum[64];

			dist_s6 <= dist_s5;
			if (!far_s5 && dist_s5 < cfg.r1sq) begin
				cls_s6 <= rgg_pkg::CLS_INNER;
			end else if (far_s5 || dist_s5 > cfg.r2sq || cfg.r_le) begin
				cls_s6 <= rgg_pkg::CLS_OUTER;
			end else begin
				cls_s6 <= rgg_pkg::CLS_MID;
			end
		end
	end

	assign out_vld = vld_s[6];
	assign dsq     = dist_s6;
	assign out_cls = cls_s6;

endmodule

### rtl/rgg_isqrt.sv
// ----------------------------------------------------------------------------
// rgg_isqrt
// Pipelined 64-bit integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module rgg_isqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [63:0]   dsq,
	input  rgg_pkg::cls_t in_cls,
	output logic          out_vld,
	output logic [31:0]   root,
	output rgg_pkg::cls_t out_cls
);

	localparam int NST = rgg_pkg::SQRT_STAGES;

	rgg_pkg::sq_t  acc_s  [NST];
	logic [63:0]   dist_s [NST];
	rgg_pkg::cls_t cls_s  [NST];
	logic [NST-1:0] vld_s;

	for (genvar j = 0; j < NST; j++) begin : g_st
		rgg_pkg::sq_t  a_in, st1, st2;
		logic [63:0]   d_in;
		rgg_pkg::cls_t c_in;
		logic          v_in;

		if (j == 0) begin : g_first
			assign a_in = '0;
			assign d_in = dsq;
			assign c_in = in_cls;
			assign v_in = in_vld;
		end else begin : g_next
			assign a_in = acc_s[j-1];
			assign d_in = dist_s[j-1];
			assign c_in = cls_s[j-1];
			assign v_in = vld_s[j-1];
		end

		assign st1 = rgg_pkg::sqrt_step(a_in, d_in[63-4*j -: 2]);
		assign st2 = rgg_pkg::sqrt_step(st1, d_in[61-4*j -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j]  <= st2;
				dist_s[j] <= d_in;
				cls_s[j]  <= c_in;
			end
		end
	end

	assign out_vld = vld_s[NST-1];
	assign root    = acc_s[NST-1].root;
	assign out_cls = cls_s[NST-1];

endmodule

### rtl/rgg_div.sv
// ----------------------------------------------------------------------------
// rgg_div
// Clamps the root into the ring and divides by the ring width, giving the
// linear gradient position in Q1.16. Restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module rgg_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [31:0]   root,
	input  rgg_pkg::cls_t in_cls,
	input  logic [31:0]   r_in,
	input  logic [31:0]   r_out,
	output logic          out_vld,
	output logic [16:0]   q,
	output rgg_pkg::cls_t out_cls
);

	localparam int NS = rgg_pkg::DIV_STEPS;

	logic [31:0] den;
	logic [32:0] den_x;
	logic [31:0] a;

	logic [32:0]   rem_s [NS+1];
	logic [16:0]   q_s   [NS+1];
	rgg_pkg::cls_t cls_s [NS+1];
	logic [NS:0]   vld_s;

	assign den   = r_out - r_in;
	assign den_x = {1'b0, den};

	always_comb begin
		if (root < r_in) begin
			a = '0;
		end else if (root > r_out) begin
			a = den;
		end else begin
			a = root - r_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, a};
			q_s[0]   <= '0;
			cls_s[0] <= in_cls;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_step
		logic [32:0] cur;
		logic        ge;

		if (j == 0) begin : g_first
			assign cur = rem_s[j];
		end else begin : g_next
			assign cur = {rem_s[j][31:0], 1'b0};
		end
		assign ge = cur >= den_x;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? 33'(cur - den_x) : cur;
				q_s[j+1]   <= {q_s[j][15:0], ge};
				cls_s[j+1] <= cls_s[j];
			end
		end
	end

	assign out_vld = vld_s[NS];
	assign q       = q_s[NS];
	assign out_cls = cls_s[NS];

endmodule

### rtl/rgg_pow.sv
// ----------------------------------------------------------------------------
// rgg_pow
// Resolves the gradient position per class and raises it to gamma:
// log2 by repeated squaring, scale by gamma, exp2 by a product of roots.
// ----------------------------------------------------------------------------
module rgg_pow (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [16:0]   q,
	input  rgg_pkg::cls_t in_cls,
	input  logic [15:0]   gam,
	output logic          out_vld,
	output logic [16:0]   t,
	output logic [16:0]   tg
);

	localparam int NL = rgg_pkg::POW_STEPS;

	typedef struct packed {
		logic [16:0] t;
		logic        sp;
		logic [16:0] spv;
	} side_t;

	// entry stage
	side_t       sd_d;
	logic [3:0]  p_d;
	logic [46:0] ext;

	// log2 pipeline
	logic [30:0] m_s    [NL+1];
	logic [15:0] frac_s [NL+1];
	logic [3:0]  p_s    [NL+1];
	side_t       lsd_s  [NL+1];
	logic [NL:0] lvld_s;

	// gamma scale
	logic [20:0] eb;
	logic [36:0] e_full;
	logic [25:0] e_e;
	side_t       esd_e;
	logic        vld_e;

	// exp2 pipeline
	logic [30:0] acc_s [NL+1];
	logic [15:0] g_s   [NL+1];
	logic [5:0]  n_s   [NL+1];
	logic        big_s [NL+1];
	logic        hv_s  [NL+1];
	side_t       xsd_s [NL+1];
	logic [NL:0] xvld_s;

	// output stage
	logic [30:0] sh, shv;
	logic [31:0] rsum;
	logic [17:0] res;
	logic [16:0] t_f, tg_f;
	logic        vld_f;

	always_comb begin
		sd_d = '0;
		case (in_cls)
			rgg_pkg::CLS_INNER: begin
				sd_d.t   = '0;
				sd_d.sp  = 1'b1;
				sd_d.spv = '0;
			end
			rgg_pkg::CLS_OUTER: begin
				sd_d.t   = rgg_pkg::T_ONE;
				sd_d.sp  = 1'b1;
				sd_d.spv = rgg_pkg::T_ONE;
			end
			default: begin
				sd_d.t  = q;
				sd_d.sp = 1'b1;
				if (gam == '0) begin
					sd_d.spv = rgg_pkg::T_ONE;
				end else if (q == '0) begin
					sd_d.spv = '0;
				end else if (q[16]) begin
					sd_d.spv = rgg_pkg::T_ONE;
				end else begin
					sd_d.sp  = 1'b0;
					sd_d.spv = '0;
				end
			end
		endcase

		// leading one of t, then normalize to Q30 in [1, 2)
		p_d = '0;
		for (int b = 0; b < 16; b++) begin
			if (q[b]) begin
				p_d = 4'(b);
			end
		end
		ext = {31'b0, q[15:0]} << (5'd30 - {1'b0, p_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvld_s[0] <= 1'b0;
		end else if (en) begin
			lvld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= ext[30:0];
			frac_s[0] <= '0;
			p_s[0]    <= p_d;
			lsd_s[0]  <= sd_d;
		end
	end

	// each squaring yields one fraction bit of log2
	for (genvar j = 0; j < NL; j++) begin : g_log
		logic [61:0] sq;
		logic [31:0] hi;

		assign sq = m_s[j] * m_s[j];
		assign hi = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lvld_s[j+1] <= 1'b0;
			end else if (en) begin
				lvld_s[j+1] <= lvld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j+1]    <= hi[31] ? hi[31:1] : hi[30:0];
				frac_s[j+1] <= {frac_s[j][14:0], hi[31]};
				p_s[j+1]    <= p_s[j];
				lsd_s[j+1]  <= lsd_s[j];
			end
		end
	end

	// -log2(t) in Q16, times gamma
	assign eb     = {5'(5'd16 - {1'b0, p_s[NL]}), 16'b0} - {5'b0, frac_s[NL]};
	assign e_full = eb * gam;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e <= 1'b0;
		end else if (en) begin
			vld_e <= lvld_s[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_e   <= e_full[36:11];
			esd_e <= lsd_s[NL];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xvld_s[0] <= 1'b0;
		end else if (en) begin
			xvld_s[0] <= vld_e;
		end
	end

	// split into whole shift and fraction; 2^-f = 2^(1 - f) / 2
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= 31'h4000_0000;
			g_s[0]   <= 16'(17'h10000 - {1'b0, e_e[15:0]});
			n_s[0]   <= e_e[21:16];
			big_s[0] <= e_e[25:16] >= 10'd40;
			hv_s[0]  <= e_e[15:0] != '0;
			xsd_s[0] <= esd_e;
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_exp
		logic [61:0] prod;

		assign prod = acc_s[k] * rgg_pkg::EXP_ROOTS[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				xvld_s[k+1] <= 1'b0;
			end else if (en) begin
				xvld_s[k+1] <= xvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1] <= g_s[k][NL-1-k] ? prod[60:30] : acc_s[k];
				g_s[k+1]   <= g_s[k];
				n_s[k+1]   <= n_s[k];
				big_s[k+1] <= big_s[k];
				hv_s[k+1]  <= hv_s[k];
				xsd_s[k+1] <= xsd_s[k];
			end
		end
	end

	always_comb begin
		sh   = hv_s[NL] ? {1'b0, acc_s[NL][30:1]} : acc_s[NL];
		shv  = sh >> n_s[NL];
		rsum = {1'b0, shv} + 32'd8192;
		res  = big_s[NL] ? 18'd0 : rsum[31:14];
		if (res > {1'b0, rgg_pkg::T_ONE}) begin
			res = {1'b0, rgg_pkg::T_ONE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f <= 1'b0;
		end else if (en) begin
			vld_f <= xvld_s[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_f  <= xsd_s[NL].t;
			tg_f <= xsd_s[NL].sp ? xsd_s[NL].spv : res[16:0];
		end
	end

	assign out_vld = vld_f;
	assign t       = t_f;
	assign tg      = tg_f;

endmodule

### rtl/radial_gradient_pixel_generator.sv
// ----------------------------------------------------------------------------
// radial_gradient_pixel_generator
// Maps a pixel through an affine transform, measures its distance to the
// gradient centre and blends start and end colours across the ring.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake              payload
//  ----------   ---  ---------------------  ------------------------------
//  config       in   cfg_we                 cfg_idx, cfg_wdata
//  pixel in     in   in_valid / in_ready    pixel_x, pixel_y
//  colour out   out  out_valid / out_ready  red, green, blue, alpha
//
//  One item per clock sustained while the output does not stall; items pass
//  through geometry, square root, ring divider, log/exp power unit and blend.
//  Reset clears only the valid bits and loads the register defaults.
//  A stall at the output holds the whole pipeline in place; in_ready drops
//  while the last stage holds an item that is not taken.
//
module radial_gradient_pixel_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rgg_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [rgg_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rgg_pkg::PIX_W-1:0]  pixel_x,
	input  logic [rgg_pkg::PIX_W-1:0]  pixel_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rgg_pkg::CH_W-1:0]   red,
	output logic [rgg_pkg::CH_W-1:0]   green,
	output logic [rgg_pkg::CH_W-1:0]   blue,
	output logic [rgg_pkg::CH_W-1:0]   alpha
);

	// configuration registers
	logic [63:0] row_x_q, row_y_q, centre_q, radii_q, start_q, end_q;
	logic [15:0] gamma_q;
	logic [63:0] r1sq_q, r2sq_q;
	logic        rle_q;

	rgg_pkg::geom_cfg_t gcfg;

	logic en;

	logic          g_vld, s_vld, d_vld, p_vld;
	logic [63:0]   g_dist;
	rgg_pkg::cls_t g_cls, s_cls, d_cls;
	logic [31:0]   s_root;
	logic [16:0]   d_q;
	logic [16:0]   p_t, p_tg;

	// blend stages
	logic [32:0] p1_s1 [4];
	logic [32:0] p2_s1 [4];
	logic [15:0] ch_s2 [4];
	logic        vld_s1, vld_s2;

	// whole pipeline moves unless the output item is held
	assign en       = ~vld_s2 | out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= 64'h0000_0001_0000_0000;
			row_y_q  <= 64'h0000_0000_0100_0000;
			centre_q <= '0;
			radii_q  <= '0;
			gamma_q  <= 16'd2048;
			start_q  <= '1;
			end_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rgg_pkg::REG_ROW_X:        row_x_q  <= cfg_wdata;
				rgg_pkg::REG_ROW_Y:        row_y_q  <= cfg_wdata;
				rgg_pkg::REG_CENTRE:       centre_q <= cfg_wdata;
				rgg_pkg::REG_RADII:        radii_q  <= cfg_wdata;
				rgg_pkg::REG_GAMMA:        gamma_q  <= cfg_wdata[15:0];
				rgg_pkg::REG_START_COLOUR: start_q  <= cfg_wdata;
				rgg_pkg::REG_END_COLOUR:   end_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// radius squares are registered from the radii register; the user must make config
	// changes only while idle, which the block does not enforce, so they are settled before any item reaches them
	always_ff @(posedge clk) begin
		r1sq_q <= radii_q[31:0] * radii_q[31:0];
		r2sq_q <= radii_q[63:32] * radii_q[63:32];
		rle_q  <= radii_q[63:32] <= radii_q[31:0];
	end

	always_comb begin
		gcfg.row_x  = row_x_q;
		gcfg.row_y  = row_y_q;
		gcfg.centre = centre_q;
		gcfg.r1sq   = r1sq_q;
		gcfg.r2sq   = r2sq_q;
		gcfg.r_le   = rle_q;
	end

	rgg_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.cfg     (gcfg),
		.out_vld (g_vld),
		.dsq     (g_dist),
		.out_cls (g_cls)
	);

	rgg_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (g_vld),
		.dsq     (g_dist),
		.in_cls  (g_cls),
		.out_vld (s_vld),
		.root    (s_root),
		.out_cls (s_cls)
	);

	rgg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_vld),
		.root    (s_root),
		.in_cls  (s_cls),
		.r_in    (radii_q[31:0]),
		.r_out   (radii_q[63:32]),
		.out_vld (d_vld),
		.q       (d_q),
		.out_cls (d_cls)
	);

	rgg_pow u_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (d_vld),
		.q       (d_q),
		.in_cls  (d_cls),
		.gam     (gamma_q),
		.out_vld (p_vld),
		.t       (p_t),
		.tg      (p_tg)
	);

	// colour blend: RGB by t^gamma, alpha by t, rounded and saturated
	for (genvar ch = 0; ch < 4; ch++) begin : g_blend
		logic [15:0] c1, c2;
		logic [16:0] w, wn;
		logic [33:0] sum;
		logic [17:0] v;

		assign c1  = start_q[16*ch +: 16] & rgg_pkg::CH_MAX;
		assign c2  = end_q[16*ch +: 16] & rgg_pkg::CH_MAX;
		assign w   = (ch == 3) ? p_t : p_tg;
		assign wn  = rgg_pkg::T_ONE - w;
		assign sum = {1'b0, p1_s1[ch]} + {1'b0, p2_s1[ch]} + 34'd32768;
		assign v   = sum[33:16];

		always_ff @(posedge clk) begin
			if (en) begin
				p1_s1[ch] <= c1 * wn;
				p2_s1[ch] <= c2 * w;
				ch_s2[ch] <= (v > {2'b00, rgg_pkg::CH_MAX}) ? rgg_pkg::CH_MAX : v[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= p_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign red       = ch_s2[0];
	assign green     = ch_s2[1];
	assign blue      = ch_s2[2];
	assign alpha     = ch_s2[3];

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel coordinates into the radial gradient generator under several
// transform, ring, gamma and colour settings. A fixed-point model of the
// datapath predicts each colour. Output items are checked in order and field
// by field, with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import rgg_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} colour_t;

	localparam int DRAIN_CYC = 100;    // comfortably past the pipeline depth
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] pixel_x = '0;
	logic [PIX_W-1:0] pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CH_W-1:0] red, green, blue, alpha;

	radial_gradient_pixel_generator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue), .alpha(alpha)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the register file, updated as each write goes out
	logic [63:0] sh_row_x = 64'h1_0000_0000;
	logic [63:0] sh_row_y = 64'h100_0000;
	logic [63:0] sh_centre = '0;
	logic [63:0] sh_radii = '0;
	logic [15:0] sh_gamma = 16'd2048;
	logic [63:0] sh_start = '1;
	logic [63:0] sh_end = '0;

	logic [63:0] exp_root [16];   // Q30 values of 2^(2^-k), k = 1..16

	pixel_t pixel_q [$];          // items waiting for the driver
	colour_t colour_due [$];      // predicted colours, oldest first
	int errors = 0;
	int idle_cyc = 0;

	// ------------------------------------------------------------------
	// fixed-point model of the datapath
	// ------------------------------------------------------------------
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, b, rem;
		r = '0;
		rem = v;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint sx(input logic [63:0] v, input int bits);
		logic signed [63:0] tmp;
		tmp = v << (64 - bits);
		return tmp >>> (64 - bits);
	endfunction

	// |centre - (x*A + y*B + offset)| on one axis, Q16
	function automatic logic [63:0] axis_gap(input longint c, input logic [63:0] row,
			input longint x, input longint y);
		longint q, d;
		q = x * sx(row, 20) + y * sx(row >> 20, 20) + sx(row >> 40, 24) * 256;
		d = c - q;
		return (d < 0) ? 64'(-d) : 64'(d);
	endfunction

	// t^gamma, t in Q1.16, gamma in Q5.11
	function automatic logic [31:0] power_q16(input logic [31:0] t, input logic [15:0] gam);
		int p;
		logic [63:0] m, frac, eb, e, n, f, acc, res;
		p = 0;
		frac = '0;
		if (gam == 0) return 32'd65536;
		if (t == 0) return 32'd0;
		if (t >= 32'd65536) return 32'd65536;
		while ((t >> (p + 1)) != 0) p++;
		m = 64'(t) << (30 - p);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		eb = 64'(16 - p) * 64'd65536 - frac;
		e = (eb * 64'(gam)) >> 11;
		n = e >> 16;
		f = e & 64'hFFFF;
		if (n >= 40) return 32'd0;
		if (f == 0) begin
			acc = 64'd1 << 30;
		end else begin
			// 2^(1 - f) built from the root table, then halved
			acc = 64'd1 << 30;
			for (int k = 1; k <= 16; k++)
				if (((64'd65536 - f) >> (16 - k)) & 64'd1)
					acc = (acc * exp_root[k-1]) >> 30;
			acc = acc >> 1;
		end
		acc = acc >> n;
		res = (acc + (64'd1 << 13)) >> 14;
		if (res > 64'd65536) res = 64'd65536;
		return res[31:0];
	endfunction

	function automatic logic [15:0] mix(input logic [63:0] c1, input logic [63:0] c2,
			input logic [31:0] w);
		logic [63:0] top, v;
		top = (64'd1 << COLOUR_BITS) - 1;
		c1 = c1 & top;
		c2 = c2 & top;
		v = (c1 * (64'd65536 - w) + c2 * w + 64'd32768) >> 16;
		if (v > top) v = top;
		return v[15:0];
	endfunction

	function automatic colour_t shade_pixel(input pixel_t px);
		longint x, y;
		logic [63:0] ax, ay, r1, r2, d2, sq_x, sq_y, s, v;
		logic [31:0] t, tg;
		logic far;
		colour_t c;
		x = longint'(px.x & COORD_MASK);
		y = longint'(px.y & COORD_MASK);
		ax = axis_gap(sx(sh_centre, 32), sh_row_x, x, y);
		ay = axis_gap(sx(sh_centre >> 32, 32), sh_row_y, x, y);
		r1 = sh_radii & 64'hFFFF_FFFF;
		r2 = sh_radii >> 32;
		d2 = '0;
		far = 1'b0;
		if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) begin
			far = 1'b1;
		end else begin
			sq_x = ax * ax;
			sq_y = ay * ay;
			d2 = sq_x + sq_y;
			if (d2 < sq_x) far = 1'b1;    // sum wrapped
		end
		if (!far && d2 < r1 * r1) begin
			t = 0;
			tg = 0;
		end else if (far || d2 > r2 * r2 || r2 <= r1) begin
			t = 32'd65536;
			tg = 32'd65536;
		end else begin
			s = root64(d2);
			if (s < r1) s = r1;
			if (s > r2) s = r2;
			v = ((s - r1) << 16) / (r2 - r1);
			if (v > 64'd65536) v = 64'd65536;
			t = v[31:0];
			tg = power_q16(t, sh_gamma);
		end
		c.r = mix(sh_start, sh_end, tg);
		c.g = mix(sh_start >> 16, sh_end >> 16, tg);
		c.b = mix(sh_start >> 32, sh_end >> 32, tg);
		c.a = mix(sh_start >> 48, sh_end >> 48, t);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// driver: bursts of items with random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid)
				colour_due.push_back(shade_pixel({pixel_x, pixel_y}));
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				nxt = pixel_q.pop_front();
				pixel_x <= nxt.x;
				pixel_y <= nxt.y;
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					// new burst; a quarter of them run back to back
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: stall pattern, in-order check, watchdog
	// ------------------------------------------------------------------
	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	int stall_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		colour_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			// open window, then a random stall stretch, repeating
			stall_phase = (stall_phase + 1) % 256;
			out_ready <= (stall_phase < 80) ? 1'b1 : ($urandom_range(0, 2) != 0);
			if (out_valid && out_ready) begin
				if (colour_due.size() == 0) begin
					$display("unexpected item %h %h %h %h", red, green, blue, alpha);
					errors++;
				end else begin
					due = colour_due.pop_front();
					if (red !== due.r) report("red", red, due.r);
					if (green !== due.g) report("green", green, due.g);
					if (blue !== due.b) report("blue", blue, due.b);
					if (alpha !== due.a) report("alpha", alpha, due.a);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_ROW_X: sh_row_x = v;
			REG_ROW_Y: sh_row_y = v;
			REG_CENTRE: sh_centre = v;
			REG_RADII: sh_radii = v;
			REG_GAMMA: sh_gamma = v[15:0];
			REG_START_COLOUR: sh_start = v;
			REG_END_COLOUR: sh_end = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// holds the sender until every predicted colour is back
	task automatic settle();
		while (pixel_q.size() != 0 || in_valid || colour_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	function automatic logic [63:0] row(input logic [19:0] ca, input logic [19:0] cb,
			input logic [23:0] off);
		return {off, cb, ca};
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic add(input int x, input int y);
		pixel_q.push_back({PIX_W'(x), PIX_W'(y)});
	endtask

	task automatic add_random(input int n);
		repeat (n) add($urandom_range(0, 4095), $urandom_range(0, 4095));
	endtask

	// a moderate transform and ring, so most pixels land in the blend zone
	task automatic random_setup(input logic full_gamma);
		logic [63:0] r1, r2;
		write_reg(REG_ROW_X, row(20'($urandom_range(0, 262143) - 131072),
			20'($urandom_range(0, 65535) - 32768), 24'($urandom_range(0, 2097151) - 1048576)));
		write_reg(REG_ROW_Y, row(20'($urandom_range(0, 65535) - 32768),
			20'($urandom_range(0, 262143) - 131072), 24'($urandom_range(0, 2097151) - 1048576)));
		write_reg(REG_CENTRE, {32'($urandom_range(0, 4096) << 16),
			32'($urandom_range(0, 4096) << 16)});
		r1 = 64'($urandom_range(0, 1500)) << 16 | 64'($urandom_range(0, 65535));
		r2 = r1 + (64'($urandom_range(1, 3000)) << 16) + 64'($urandom_range(0, 65535));
		write_reg(REG_RADII, {r2[31:0], r1[31:0]});
		write_reg(REG_GAMMA, full_gamma ? 16'($urandom) : 16'($urandom_range(205, 40960)));
		write_reg(REG_START_COLOUR, rnd64());
		write_reg(REG_END_COLOUR, rnd64());
	endtask

	localparam logic [19:0] Q16_ONE = 20'h10000;

	initial begin
		logic [63:0] rt;
		rt = root64(64'd2 << 60);
		for (int k = 0; k < 16; k++) begin
			exp_root[k] = rt;
			rt = root64(rt << 30);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: corners and one inner point
		add(0, 0); add(4095, 4095); add(4095, 0); add(0, 4095); add(1, 1);
		settle();

		// plain mapping, ring 500..1500 around the middle of the raster
		write_reg(REG_ROW_X, row(Q16_ONE, 20'd0, 24'd0));
		write_reg(REG_ROW_Y, row(20'd0, Q16_ONE, 24'd0));
		write_reg(REG_CENTRE, {32'd2048 << 16, 32'd2048 << 16});
		write_reg(REG_RADII, {32'd1500 << 16, 32'd500 << 16});
		write_reg(REG_GAMMA, 16'd2048);
		write_reg(REG_START_COLOUR, 64'hFFFF_8000_0001_FFFF);
		write_reg(REG_END_COLOUR, 64'h0000_7FFF_FFFE_0000);
		add(2048, 2048); add(2547, 2048); add(2548, 2048); add(2549, 2048);
		add(3548, 2048); add(3549, 2048); add(2048, 3000); add(1000, 1000);
		add_random(170);
		settle();

		// equal radii with zero gamma: on the circle t is one
		write_reg(REG_RADII, {32'd1000 << 16, 32'd1000 << 16});
		write_reg(REG_GAMMA, 16'd0);
		add(3048, 2048); add(1048, 2048); add(2048, 1048); add(3047, 2048);
		add_random(30);
		settle();

		// outer radius below inner, zero gamma across a real ring
		write_reg(REG_RADII, {32'd300 << 16, 32'd900 << 16});
		add(2048, 2048); add(2948, 2048); add(3500, 2048);
		add_random(40);
		settle();
		write_reg(REG_RADII, {32'd1800 << 16, 32'd10 << 16});
		add(2048, 2048); add(2058, 2048);
		add_random(130);
		settle();

		// extremes: all-ones rows and radii, max gamma, full colours
		write_reg(REG_ROW_X, '1);
		write_reg(REG_ROW_Y, '1);
		write_reg(REG_CENTRE, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_RADII, '1);
		write_reg(REG_GAMMA, 16'hFFFF);
		write_reg(REG_START_COLOUR, '0);
		write_reg(REG_END_COLOUR, '1);
		add(0, 0); add(4095, 4095);
		add_random(60);
		settle();

		// huge coefficients: far pixels and wrapped sums
		write_reg(REG_ROW_X, row(20'h7FFFF, 20'h7FFFF, 24'h7FFFFF));
		write_reg(REG_ROW_Y, row(20'h80000, 20'h80000, 24'h800000));
		write_reg(REG_CENTRE, '0);
		write_reg(REG_RADII, {32'hFFFF_FFFF, 32'd0});
		add(0, 0); add(4095, 4095);
		add_random(40);
		settle();

		// random settings, mostly in range, then any gamma code
		repeat (4) begin
			random_setup(1'b0);
			add_random(110);
			settle();
		end
		repeat (2) begin
			random_setup(1'b1);
			add_random(70);
			settle();
		end

		// fully random registers
		write_reg(REG_ROW_X, rnd64());
		write_reg(REG_ROW_Y, rnd64());
		write_reg(REG_CENTRE, rnd64());
		write_reg(REG_RADII, rnd64());
		write_reg(REG_GAMMA, 64'($urandom));
		add_random(40);
		settle();

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### filelist.f
rtl/rgg_pkg.sv
rtl/rgg_geom.sv
rtl/rgg_isqrt.sv
rtl/rgg_div.sv
rtl/rgg_pow.sv
rtl/radial_gradient_pixel_generator.sv
tb/tb_top.sv
